// ===== rtl/core/psa_pkg.sv =====
package psa_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_X    = 8'h58;

  localparam logic [2:0] CAT_ALPHA = 3'b001;
  localparam logic [2:0] CAT_NUM   = 3'b010;
  localparam logic [2:0] CAT_NAT   = 3'b100;

  localparam int unsigned MAX_SIG_DIGITS = 9;

  typedef struct packed {
    logic [7:0]  run_char;
    logic        run_open;
    logic [30:0] run_len;
    logic        in_count;
    logic [29:0] count_value;
    logic [3:0]  count_sig;
    logic [2:0]  category;
    logic        sign_seen;
    logic        point_seen;
    logic        symbol_seen;
    logic [30:0] digit_total;
    logic [30:0] scale_total;
    logic        failed;
    logic        content_ended;
  } st_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] digit_count;
    logic [30:0] scale;
    logic        signed_flag;
    logic [2:0]  category;
  } res_t;

endpackage

// ===== rtl/core/picture_string_analyzer.sv =====
// Picture string analyser.
// Input channel: in_ch carries one picture byte per transaction, in_is_last
// marks the final byte of a string. A transaction completes on a rising edge
// with in_valid high and in_stall low.
// Result channel: exactly one result per string, given for the byte with
// in_is_last set; out_ok, out_digit_count, out_scale, out_signed_flag and
// out_category, all zero, out_ok included, when the picture is invalid.
// Throughput: one byte per cycle while in_stall is low; each byte passes
// an input register, one update of the parse state and, for the final
// byte, the result register.
// Stall: a stalled result holds; further bytes keep flowing until the next
// final byte reaches the parse stage while the result register is still full,
// then in_stall rises.
// Reset: synchronous on rst_n low; the parse state, input and result stages
// are emptied and the block starts a fresh string.
module picture_string_analyzer #(
  parameter int MAX_LEN = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [30:0] out_digit_count,
  output logic [30:0] out_scale,
  output logic        out_signed_flag,
  output logic [2:0]  out_category
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic          s1_valid_r;
  logic [7:0]    s1_ch_r;
  logic          s1_last_r;
  psa_pkg::st_t  state_r;
  psa_pkg::st_t  state_nxt;
  logic [CW-1:0] char_count_r;
  logic [CW-1:0] char_count_nxt;
  psa_pkg::res_t res_nxt;
  psa_pkg::res_t res_r;
  logic          out_valid_r;
  logic          s1_adv;
  logic          in_take;

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  psa_step #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW)
  ) u_step (
    .st             (state_r),
    .char_count     (char_count_r),
    .ch             (s1_ch_r),
    .is_last        (s1_last_r),
    .st_nxt         (state_nxt),
    .char_count_nxt (char_count_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      state_r      <= '0;
      char_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        state_r      <= state_nxt;
        char_count_r <= char_count_nxt;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_is_last;
    end
    if (s1_adv && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = res_r.ok;
  assign out_digit_count = res_r.digit_count;
  assign out_scale       = res_r.scale;
  assign out_signed_flag = res_r.signed_flag;
  assign out_category    = res_r.category;

endmodule

// ===== rtl/core/psa_step.sv =====
module psa_step #(
  parameter int MAX_LEN = 50,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  psa_pkg::st_t  st,
  input  logic [CW-1:0] char_count,
  input  logic [7:0]    ch,
  input  logic          is_last,
  output psa_pkg::st_t  st_nxt,
  output logic [CW-1:0] char_count_nxt,
  output psa_pkg::res_t res
);

  function automatic psa_pkg::st_t add_to_run(psa_pkg::st_t s, logic [29:0] k);
    psa_pkg::st_t r;
    logic [31:0]  t;
    r = s;
    t = {1'b0, s.run_len} + {2'b00, k};
    if (t[31]) begin
      r.failed = 1'b1;
    end else begin
      r.run_len = t[30:0];
    end
    return r;
  endfunction

  function automatic psa_pkg::st_t classify(psa_pkg::st_t s);
    psa_pkg::st_t r;
    logic [31:0]  d;
    logic [31:0]  q;
    r = s;
    d = {1'b0, s.digit_total} + {1'b0, s.run_len};
    q = {1'b0, s.scale_total} + {1'b0, s.run_len};
    case (s.run_char)
      psa_pkg::CH_X, psa_pkg::CH_N: begin
        if (s.sign_seen || s.point_seen) begin
          r.failed = 1'b1;
        end else begin
          r.category = r.category | ((s.run_char == psa_pkg::CH_X) ?
                       (psa_pkg::CAT_ALPHA | psa_pkg::CAT_NUM) : psa_pkg::CAT_NAT);
          if (d[31]) begin
            r.failed = 1'b1;
          end else begin
            r.digit_total = d[30:0];
          end
          r.symbol_seen = 1'b1;
        end
      end
      psa_pkg::CH_9: begin
        r.category = r.category | psa_pkg::CAT_NUM;
        if (d[31]) begin
          r.failed = 1'b1;
        end else begin
          r.digit_total = d[30:0];
        end
        if (s.point_seen) begin
          if (q[31]) begin
            r.failed = 1'b1;
          end else begin
            r.scale_total = q[30:0];
          end
        end
        r.symbol_seen = 1'b1;
      end
      psa_pkg::CH_S: begin
        r.category = r.category | psa_pkg::CAT_NUM;
        if ((s.category & psa_pkg::CAT_ALPHA) != 3'b000 || s.sign_seen ||
            s.run_len > 31'd1 || s.symbol_seen) begin
          r.failed = 1'b1;
        end else begin
          r.sign_seen = 1'b1;
        end
      end
      psa_pkg::CH_V: begin
        r.category = r.category | psa_pkg::CAT_NUM;
        if ((s.category & psa_pkg::CAT_ALPHA) != 3'b000 || s.point_seen ||
            s.run_len > 31'd1) begin
          r.failed = 1'b1;
        end else begin
          r.point_seen  = 1'b1;
          r.symbol_seen = 1'b1;
        end
      end
      default: begin
        r.symbol_seen = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic psa_pkg::st_t end_content(psa_pkg::st_t s);
    psa_pkg::st_t r;
    r = s;
    if (s.in_count) begin
      r.failed = 1'b1;
    end else if (s.run_open) begin
      r = classify(s);
    end
    r.run_open      = 1'b0;
    r.content_ended = 1'b1;
    return r;
  endfunction

  function automatic psa_pkg::st_t take_byte(psa_pkg::st_t s, logic [7:0] c);
    psa_pkg::st_t r;
    logic [7:0]   dv;
    logic [33:0]  m;
    logic [4:0]   sig;
    r   = s;
    dv  = c - psa_pkg::CH_0;
    m   = ({4'b0000, s.count_value} << 3) + ({4'b0000, s.count_value} << 1) +
          {30'd0, dv[3:0]};
    sig = {1'b0, s.count_sig} + 5'd1;
    if (c == psa_pkg::CH_NUL) begin
      r = end_content(s);
    end else if (s.in_count) begin
      if (c == psa_pkg::CH_RPAR) begin
        if (s.count_value == 30'd0) begin
          r.failed = 1'b1;
        end else begin
          r = add_to_run(s, s.count_value - 30'd1);
          r.in_count = 1'b0;
        end
      end else if (c inside {[psa_pkg::CH_0 : psa_pkg::CH_9]}) begin
        if (!(c == psa_pkg::CH_0 && s.count_sig == 4'd0)) begin
          r.count_sig = sig[3:0];
          if (sig > 5'(psa_pkg::MAX_SIG_DIGITS)) begin
            r.failed = 1'b1;
          end else begin
            r.count_value = m[29:0];
          end
        end
      end else begin
        r.failed = 1'b1;
      end
    end else if (s.run_open && c == s.run_char) begin
      r = add_to_run(s, 30'd1);
    end else if (s.run_open && c == psa_pkg::CH_LPAR) begin
      r.in_count    = 1'b1;
      r.count_value = 30'd0;
      r.count_sig   = 4'd0;
    end else begin
      if (s.run_open) begin
        r = classify(s);
      end
      if (!r.failed) begin
        r.run_char = c;
        r.run_open = 1'b1;
        r.run_len  = 31'd1;
      end
    end
    return r;
  endfunction

  psa_pkg::st_t  s;
  logic [CW-1:0] cnt;

  always_comb begin
    s   = st;
    cnt = char_count;
    if (cnt >= CW'(MAX_LEN)) begin
      s.failed = 1'b1;
    end else begin
      cnt = cnt + CW'(1);
    end
    if (!s.failed && !s.content_ended) begin
      s = take_byte(s, ch);
    end
    res = '0;
    st_nxt         = s;
    char_count_nxt = cnt;
    if (is_last) begin
      if (!s.failed && !s.content_ended) begin
        s = end_content(s);
      end
      if (!s.failed) begin
        res.ok          = 1'b1;
        res.digit_count = s.digit_total;
        res.scale       = s.scale_total;
        res.signed_flag = s.sign_seen;
        res.category    = s.category;
      end
      st_nxt         = '0;
      char_count_nxt = '0;
    end
  end

endmodule
